@@ rtl/core/dsb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dsb_pkg
// Shared types and constants of the domain suffix blocklist: function codes,
// table states, sequencer states and the compare unit's interface.
// ----------------------------------------------------------------------------
package dsb_pkg;

  localparam int ENTRY_DEPTH_DEF = 4096;
  localparam int TEXT_BYTES_DEF  = 65536;
  localparam int NAME_MAX_DEF    = 253;

  localparam int DROP_W = 16;
  localparam logic [DROP_W-1:0] DROP_MAX = '1;

  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_FIN   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [1:0] MODE_EMPTY   = 2'd0;
  localparam logic [1:0] MODE_LOADING = 2'd1;
  localparam logic [1:0] MODE_ACTIVE  = 2'd2;

  localparam logic [7:0] DOT_BYTE = 8'h2E;
  localparam logic [7:0] NUL_BYTE = 8'h00;

  typedef enum logic [1:0] {
    CMP_LT,
    CMP_EQ,
    CMP_GT
  } cmp_res_t;

  typedef enum logic {
    CMP_ENTRY,
    CMP_PREFIX
  } cmp_mode_t;

  typedef struct packed {
    logic     done;
    cmp_res_t res;
  } cmp_step_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ADD,
    S_QRY,
    S_QS_ISSUE,
    S_QS_EVAL,
    S_BS_MID,
    S_BS_OFF,
    S_BS_DEC,
    S_FIN,
    S_BUILD,
    S_SK_ROOT,
    S_SK_LOADV,
    S_SK_TOP,
    S_SK_C0,
    S_SK_C1,
    S_SK_PICK,
    S_SK_CMP,
    S_SK_DEC,
    S_SK_FIN,
    S_EX,
    S_EX_V,
    S_EX_T,
    S_DD_INIT,
    S_DD_P,
    S_DD_RD,
    S_DD_C,
    S_DD_DEC,
    S_C_ISSUE,
    S_C_EVAL,
    S_RESULT
  } state_t;

endpackage
`default_nettype wire

@@ rtl/core/dsb_cmp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dsb_cmp
// Byte step of the shared string compare unit: decides, from one byte pair,
// whether an entry-to-entry or entry-to-prefix compare is settled.
// ----------------------------------------------------------------------------
module dsb_cmp (
  input  wire dsb_pkg::cmp_mode_t mode,
  input  wire logic [7:0]         x,
  input  wire logic [7:0]         y,
  input  wire logic               at_end,
  output dsb_pkg::cmp_step_t      step
);
  import dsb_pkg::*;

  cmp_res_t ne_res;

  assign ne_res = (x < y) ? CMP_LT : CMP_GT;

  always_comb begin
    step.done = 1'b0;
    step.res  = CMP_EQ;
    unique case (mode)
      CMP_PREFIX: begin
        if (at_end) begin
          step.done = 1'b1;
          step.res  = (x == NUL_BYTE) ? CMP_EQ : CMP_GT;
        end else if (x == NUL_BYTE) begin
          step.done = 1'b1;
          step.res  = CMP_LT;
        end else if (x != y) begin
          step.done = 1'b1;
          step.res  = ne_res;
        end
      end
      CMP_ENTRY: begin
        if (x != y) begin
          step.done = 1'b1;
          step.res  = ne_res;
        end else if (x == NUL_BYTE) begin
          step.done = 1'b1;
          step.res  = CMP_EQ;
        end
      end
      default: begin
        step.done = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/domain_suffix_blocklist.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// domain_suffix_blocklist
// Sorted string table of names with label-boundary suffix lookup.
// ----------------------------------------------------------------------------
// Name bytes enter at one byte per cycle while req_ready is high (only in
// S_IDLE). An add or query ends with its last byte; the block then works
// alone until its result word is loaded. All string work runs through one
// byte compare unit: each byte pair is read from the registered memories
// in S_C_ISSUE and decided in S_C_EVAL. A query runs a binary search, about
// log2(entries)+1 probes, for the full name and again for each '.' in it.
// Finalize is a heapsort followed by a duplicate sweep, roughly
// 2*N*log2(N) entry compares. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module domain_suffix_blocklist #(
  parameter int ENTRY_DEPTH = dsb_pkg::ENTRY_DEPTH_DEF,
  parameter int TEXT_BYTES  = dsb_pkg::TEXT_BYTES_DEF,
  parameter int NAME_MAX    = dsb_pkg::NAME_MAX_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               req_valid,
  output logic                                    req_ready,
  input  wire logic [1:0]                         func,
  input  wire logic [7:0]                         data_byte,
  input  wire logic                               last,
  output logic                                    rsp_valid,
  input  wire logic                               rsp_ready,
  output logic [1:0]                              kind,
  output logic                                    ok,
  output logic [$clog2(ENTRY_DEPTH+1)-1:0]        stored_entries,
  output logic [dsb_pkg::DROP_W-1:0]              dropped_entries,
  output logic [1:0]                              table_state
);
  import dsb_pkg::*;

  localparam int TW  = $clog2(TEXT_BYTES);
  localparam int UW  = TW + 1;
  localparam int EW  = $clog2(ENTRY_DEPTH);
  localparam int NW  = $clog2(ENTRY_DEPTH + 1);
  localparam int CW  = $clog2(NAME_MAX + 2);
  localparam int QAW = (NAME_MAX > 1) ? $clog2(NAME_MAX) : 1;

  localparam logic [CW-1:0]   NMAX    = CW'(NAME_MAX);
  localparam logic [UW:0]     TBYTES  = (UW+1)'(TEXT_BYTES);
  localparam logic [NW-1:0]   EDEPTH  = NW'(ENTRY_DEPTH);

  logic [7:0]    text_mem [TEXT_BYTES];
  logic [TW-1:0] off_mem  [ENTRY_DEPTH];
  logic [7:0]    q_mem    [NAME_MAX];

  logic [7:0]    ta_q, tb_q, qd_q;
  logic [TW-1:0] od_q;

  logic          text_we;
  logic [TW-1:0] text_wa, ta_addr, tb_addr;
  logic [7:0]    text_wd;
  logic          off_we;
  logic [EW-1:0] off_wa, off_ra;
  logic [TW-1:0] off_wd;
  logic          q_we;
  logic [QAW-1:0] q_wa, q_ra;

  state_t        state, state_next;
  state_t        cret, cret_next, sink_ret, sink_ret_next;
  cmp_mode_t     cmode, cmode_next;
  cmp_res_t      cres, cres_next;
  cmp_step_t     cstep;

  logic [CW-1:0] byte_counter, byte_counter_next;
  logic [CW-1:0] qlen, qlen_next, p, p_next, plen, plen_next, ci, ci_next;
  logic [UW-1:0] text_used, text_used_next;
  logic [NW-1:0] entry_total, entry_total_next;
  logic [DROP_W-1:0] drop_total, drop_total_next;
  logic [1:0]    list_mode, list_mode_next;
  logic [1:0]    res_kind, res_kind_next;
  logic          res_ok, res_ok_next;
  logic [NW-1:0] lo, lo_next, hi, hi_next, hn, hn_next, bi, bi_next;
  logic [NW-1:0] en, en_next, w, w_next, di, di_next;
  logic [EW-1:0] mid, mid_next, root, root_next, child, child_next;
  logic [TW-1:0] sv, sv_next, oc, oc_next, oc1, oc1_next;
  logic [TW-1:0] ca, ca_next, cb, cb_next;

  logic [CW-1:0] cnt_inc;
  logic [NW-1:0] mid_c;
  logic [EW:0]   child_c, child_p1;
  logic [UW:0]   spec_pos, need;
  logic          cmp_at_end;
  logic [7:0]    cmp_y;

  dsb_cmp u_cmp (
    .mode   (cmode),
    .x      (ta_q),
    .y      (cmp_y),
    .at_end (cmp_at_end),
    .step   (cstep)
  );

  assign cmp_y      = (cmode == CMP_PREFIX) ? qd_q : tb_q;
  assign cmp_at_end = (cmode == CMP_PREFIX) && (ci == plen);
  assign ta_addr    = ca + TW'(ci);
  assign tb_addr    = cb + TW'(ci);
  assign q_ra       = (state == S_QS_ISSUE) ? p[QAW-1:0] : ci[QAW-1:0];
  assign q_wa       = byte_counter[QAW-1:0];
  assign cnt_inc    = byte_counter + CW'(byte_counter <= NMAX);
  assign mid_c      = lo + ((hi - lo) >> 1);
  assign child_c    = {root, 1'b1};
  assign child_p1   = {1'b0, child} + (EW+1)'(1);
  assign spec_pos   = (UW+1)'(text_used) + (UW+1)'(byte_counter);
  assign need       = (UW+1)'(text_used) + (UW+1)'(qlen) + (UW+1)'(1);
  assign req_ready  = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (text_we) begin
      text_mem[text_wa] <= text_wd;
    end
    ta_q <= text_mem[ta_addr];
    tb_q <= text_mem[tb_addr];
  end

  always_ff @(posedge clk) begin
    if (off_we) begin
      off_mem[off_wa] <= off_wd;
    end
    od_q <= off_mem[off_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_wa] <= data_byte;
    end
    qd_q <= q_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      byte_counter <= '0;
      text_used    <= '0;
      entry_total  <= '0;
      drop_total   <= '0;
      list_mode    <= MODE_EMPTY;
      rsp_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      byte_counter <= byte_counter_next;
      text_used    <= text_used_next;
      entry_total  <= entry_total_next;
      drop_total   <= drop_total_next;
      list_mode    <= list_mode_next;
      if (state == S_RESULT && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cret     <= cret_next;
    sink_ret <= sink_ret_next;
    cmode    <= cmode_next;
    cres     <= cres_next;
    qlen     <= qlen_next;
    p        <= p_next;
    plen     <= plen_next;
    ci       <= ci_next;
    res_kind <= res_kind_next;
    res_ok   <= res_ok_next;
    lo       <= lo_next;
    hi       <= hi_next;
    hn       <= hn_next;
    bi       <= bi_next;
    en       <= en_next;
    w        <= w_next;
    di       <= di_next;
    mid      <= mid_next;
    root     <= root_next;
    child    <= child_next;
    sv       <= sv_next;
    oc       <= oc_next;
    oc1      <= oc1_next;
    ca       <= ca_next;
    cb       <= cb_next;
    if (state == S_RESULT && (!rsp_valid || rsp_ready)) begin
      kind            <= res_kind;
      ok              <= res_ok;
      stored_entries  <= entry_total;
      dropped_entries <= drop_total;
      table_state     <= list_mode;
    end
  end

  always_comb begin
    state_next        = state;
    cret_next         = cret;
    sink_ret_next     = sink_ret;
    cmode_next        = cmode;
    cres_next         = cres;
    byte_counter_next = byte_counter;
    qlen_next         = qlen;
    p_next            = p;
    plen_next         = plen;
    ci_next           = ci;
    text_used_next    = text_used;
    entry_total_next  = entry_total;
    drop_total_next   = drop_total;
    list_mode_next    = list_mode;
    res_kind_next     = res_kind;
    res_ok_next       = res_ok;
    lo_next           = lo;
    hi_next           = hi;
    hn_next           = hn;
    bi_next           = bi;
    en_next           = en;
    w_next            = w;
    di_next           = di;
    mid_next          = mid;
    root_next         = root;
    child_next        = child;
    sv_next           = sv;
    oc_next           = oc;
    oc1_next          = oc1;
    ca_next           = ca;
    cb_next           = cb;
    text_we           = 1'b0;
    text_wa           = TW'(spec_pos);
    text_wd           = data_byte;
    off_we            = 1'b0;
    off_wa            = root;
    off_wd            = sv;
    off_ra            = mid;
    q_we              = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          res_kind_next = func;
          unique case (func)
            FUNC_ADD, FUNC_QUERY: begin
              if (byte_counter < NMAX) begin
                q_we    = 1'b1;
                text_we = (spec_pos < TBYTES);
              end
              if (last) begin
                byte_counter_next = '0;
                qlen_next         = cnt_inc;
                state_next        = (func == FUNC_ADD) ? S_ADD : S_QRY;
              end else begin
                byte_counter_next = cnt_inc;
              end
            end
            FUNC_FIN: begin
              byte_counter_next = '0;
              state_next        = S_FIN;
            end
            FUNC_CLEAR: begin
              byte_counter_next = '0;
              text_used_next    = '0;
              entry_total_next  = '0;
              drop_total_next   = '0;
              list_mode_next    = MODE_EMPTY;
              res_ok_next       = 1'b1;
              state_next        = S_RESULT;
            end
            default: ;
          endcase
        end
      end

      S_ADD: begin
        res_ok_next = 1'b0;
        state_next  = S_RESULT;
        if (qlen <= NMAX) begin
          list_mode_next = MODE_LOADING;
          if (entry_total >= EDEPTH || need > TBYTES) begin
            if (drop_total != DROP_MAX) begin
              drop_total_next = drop_total + DROP_W'(1);
            end
          end else begin
            text_we          = 1'b1;
            text_wa          = TW'(text_used) + TW'(qlen);
            text_wd          = NUL_BYTE;
            off_we           = 1'b1;
            off_wa           = EW'(entry_total);
            off_wd           = TW'(text_used);
            entry_total_next = entry_total + NW'(1);
            text_used_next   = UW'(need);
            res_ok_next      = 1'b1;
          end
        end
      end

      S_QRY: begin
        if (list_mode != MODE_ACTIVE || entry_total == '0 || qlen > NMAX) begin
          res_ok_next = 1'b0;
          state_next  = S_RESULT;
        end else begin
          p_next     = '0;
          state_next = S_QS_ISSUE;
        end
      end

      S_QS_ISSUE: begin
        state_next = S_QS_EVAL;
      end

      S_QS_EVAL: begin
        if (p == qlen || qd_q == DOT_BYTE) begin
          plen_next  = p;
          lo_next    = '0;
          hi_next    = entry_total;
          state_next = S_BS_MID;
        end else begin
          p_next     = p + CW'(1);
          state_next = S_QS_ISSUE;
        end
      end

      S_BS_MID: begin
        if (lo >= hi) begin
          if (p == qlen) begin
            res_ok_next = 1'b0;
            state_next  = S_RESULT;
          end else begin
            p_next     = p + CW'(1);
            state_next = S_QS_ISSUE;
          end
        end else begin
          off_ra     = EW'(mid_c);
          mid_next   = EW'(mid_c);
          state_next = S_BS_OFF;
        end
      end

      S_BS_OFF: begin
        ca_next    = od_q;
        ci_next    = '0;
        cmode_next = CMP_PREFIX;
        cret_next  = S_BS_DEC;
        state_next = S_C_ISSUE;
      end

      S_BS_DEC: begin
        state_next = S_BS_MID;
        unique case (cres)
          CMP_EQ: begin
            res_ok_next = 1'b1;
            state_next  = S_RESULT;
          end
          CMP_LT:  lo_next = NW'(mid) + NW'(1);
          default: hi_next = NW'(mid);
        endcase
      end

      S_FIN: begin
        if (entry_total <= NW'(1)) begin
          w_next     = entry_total;
          di_next    = NW'(1);
          state_next = S_DD_RD;
        end else begin
          hn_next    = entry_total;
          bi_next    = entry_total >> 1;
          state_next = S_BUILD;
        end
      end

      S_BUILD: begin
        if (bi == '0) begin
          en_next    = entry_total;
          state_next = S_EX;
        end else begin
          root_next     = EW'(bi - NW'(1));
          bi_next       = bi - NW'(1);
          sink_ret_next = S_BUILD;
          state_next    = S_SK_ROOT;
        end
      end

      S_SK_ROOT: begin
        off_ra     = root;
        state_next = S_SK_LOADV;
      end

      S_SK_LOADV: begin
        sv_next    = od_q;
        state_next = S_SK_TOP;
      end

      S_SK_TOP: begin
        if (child_c >= (EW+1)'(hn)) begin
          state_next = S_SK_FIN;
        end else begin
          off_ra     = EW'(child_c);
          child_next = EW'(child_c);
          state_next = S_SK_C0;
        end
      end

      S_SK_C0: begin
        oc_next = od_q;
        if (child_p1 < (EW+1)'(hn)) begin
          off_ra     = EW'(child_p1);
          state_next = S_SK_C1;
        end else begin
          state_next = S_SK_CMP;
        end
      end

      S_SK_C1: begin
        oc1_next   = od_q;
        ca_next    = oc;
        cb_next    = od_q;
        ci_next    = '0;
        cmode_next = CMP_ENTRY;
        cret_next  = S_SK_PICK;
        state_next = S_C_ISSUE;
      end

      S_SK_PICK: begin
        if (cres == CMP_LT) begin
          child_next = EW'(child_p1);
          oc_next    = oc1;
        end
        state_next = S_SK_CMP;
      end

      S_SK_CMP: begin
        ca_next    = sv;
        cb_next    = oc;
        ci_next    = '0;
        cmode_next = CMP_ENTRY;
        cret_next  = S_SK_DEC;
        state_next = S_C_ISSUE;
      end

      S_SK_DEC: begin
        if (cres == CMP_LT) begin
          off_we     = 1'b1;
          off_wa     = root;
          off_wd     = oc;
          root_next  = child;
          state_next = S_SK_TOP;
        end else begin
          state_next = S_SK_FIN;
        end
      end

      S_SK_FIN: begin
        off_we     = 1'b1;
        off_wa     = root;
        off_wd     = sv;
        state_next = sink_ret;
      end

      S_EX: begin
        if (en <= NW'(1)) begin
          state_next = S_DD_INIT;
        end else begin
          off_ra     = EW'(en - NW'(1));
          en_next    = en - NW'(1);
          state_next = S_EX_V;
        end
      end

      S_EX_V: begin
        sv_next    = od_q;
        off_ra     = '0;
        state_next = S_EX_T;
      end

      S_EX_T: begin
        off_we        = 1'b1;
        off_wa        = EW'(en);
        off_wd        = od_q;
        hn_next       = en;
        root_next     = '0;
        sink_ret_next = S_EX;
        state_next    = S_SK_TOP;
      end

      S_DD_INIT: begin
        off_ra     = '0;
        w_next     = NW'(1);
        di_next    = NW'(1);
        state_next = S_DD_P;
      end

      S_DD_P: begin
        cb_next    = od_q;
        state_next = S_DD_RD;
      end

      S_DD_RD: begin
        if (di >= entry_total) begin
          entry_total_next = w;
          list_mode_next   = MODE_ACTIVE;
          res_ok_next      = 1'b1;
          state_next       = S_RESULT;
        end else begin
          off_ra     = EW'(di);
          state_next = S_DD_C;
        end
      end

      S_DD_C: begin
        ca_next    = od_q;
        ci_next    = '0;
        cmode_next = CMP_ENTRY;
        cret_next  = S_DD_DEC;
        state_next = S_C_ISSUE;
      end

      S_DD_DEC: begin
        if (cres != CMP_EQ) begin
          off_we  = 1'b1;
          off_wa  = EW'(w);
          off_wd  = ca;
          w_next  = w + NW'(1);
          cb_next = ca;
        end
        di_next    = di + NW'(1);
        state_next = S_DD_RD;
      end

      S_C_ISSUE: begin
        state_next = S_C_EVAL;
      end

      S_C_EVAL: begin
        if (cstep.done) begin
          cres_next  = cstep.res;
          state_next = cret;
        end else begin
          ci_next    = ci + CW'(1);
          state_next = S_C_ISSUE;
        end
      end

      S_RESULT: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/dsb_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dsb_checker
// Port-level checks of the blocklist's result words, bound to the top level.
// ----------------------------------------------------------------------------
module dsb_checker #(
  parameter int ENTRY_DEPTH = dsb_pkg::ENTRY_DEPTH_DEF
) (
  input wire logic                               clk,
  input wire logic                               rst,
  input wire logic                               rsp_valid,
  input wire logic                               rsp_ready,
  input wire logic [1:0]                         kind,
  input wire logic                               ok,
  input wire logic [$clog2(ENTRY_DEPTH+1)-1:0]   stored_entries,
  input wire logic [dsb_pkg::DROP_W-1:0]         dropped_entries,
  input wire logic [1:0]                         table_state
);
  import dsb_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(ok)
      && $stable(stored_entries) && $stable(table_state))
    else $error("result word changed while stalled");

  a_ctl_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (kind == FUNC_FIN || kind == FUNC_CLEAR) |-> ok)
    else $error("finalize or clear word without ok");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind == FUNC_CLEAR |-> stored_entries == '0
      && dropped_entries == '0 && table_state == MODE_EMPTY)
    else $error("clear word shows a non-empty table");

  a_fin: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind == FUNC_FIN |-> table_state == MODE_ACTIVE)
    else $error("finalize word without active table");

  a_hit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && kind == FUNC_QUERY && ok |->
      table_state == MODE_ACTIVE && stored_entries != '0)
    else $error("query hit on an inactive or empty table");

endmodule

bind domain_suffix_blocklist dsb_checker #(.ENTRY_DEPTH(ENTRY_DEPTH)) u_dsb_checker (.*);
`default_nettype wire
